### rtl/isvm_pkg.sv
// Package for the interpolating sample voice mixer.
// Holds payload structs, opcodes, controller states and the controller/datapath interface.
package isvm_pkg;

   localparam int VOICES           = 8;
   localparam int VOICE_BITS       = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int SAMPLE_ADDR_BITS = 16;
   localparam int MEM_WORDS        = 1 << SAMPLE_ADDR_BITS;

   localparam logic signed [16:0] SAT_MAX = 17'sh07fff;
   localparam logic signed [16:0] SAT_MIN = -17'sh08000;

   localparam logic [2:0] WRAP_TOP = 3'd7;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_MIX   = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [15:0]         address;
      logic signed [15:0]  sample_value;
      logic [16:0]         sound_length;
      logic [23:0]         step_rate;
      logic                loop_flag;
      logic [15:0]         stop_handle;
   } req_type;

   typedef struct packed {
      logic signed [15:0]  mixed_sample;
      logic [15:0]         voice_handle;
      logic                rejected;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_LEFT,
      ST_RD_RIGHT,
      ST_MUL,
      ST_ACC,
      ST_WRAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  load;
      logic                  exec_simple;
      logic                  rd_left;
      logic                  rd_right;
      logic                  mul;
      logic                  acc;
      logic                  wrap;
      logic [2:0]            shift;
      logic [VOICE_BITS-1:0] voice;
   } cmd_type;

   typedef struct packed {
      logic [VOICES-1:0] active;
      logic              wrap_more;
   } sts_type;

endpackage

### rtl/isvm_datapath.sv
// Datapath: sample memory, voice registers, interpolation multiplier and saturating mix.
// Depends on isvm_pkg; driven by isvm_controller commands.
module isvm_datapath
   import isvm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_in,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_word
);

   logic signed [15:0] mem [MEM_WORDS];

   req_type            req_ff;
   logic [VOICES-1:0]  active_ff, active_in;
   logic [15:0]        base_ff   [VOICES];
   logic [16:0]        length_ff [VOICES];
   logic [31:0]        pos_ff    [VOICES];
   logic [23:0]        rate_ff   [VOICES];
   logic [VOICES-1:0]  loops_ff;
   logic [15:0]        id_ff     [VOICES];
   logic [15:0]        handle_ff;
   logic signed [16:0] mix_ff;
   logic signed [15:0] left_ff, rd_ff;
   logic signed [33:0] prod_ff;
   rsp_type            rsp_ff;

   logic [VOICE_BITS-1:0] free_v;
   logic                  free_found;
   logic [15:0]           ipos;
   logic [15:0]           rd_addr;
   logic                  last_idx;
   logic signed [15:0]    right_val;
   logic signed [33:0]    prod_in;
   logic signed [33:0]    interp_q;
   logic signed [17:0]    sum;
   logic signed [16:0]    sat;
   logic [32:0]           adv;
   logic [32:0]           limit;
   logic [32:0]           wrapped;
   logic [40:0]           wrap_amt;

   assign sts.active    = active_ff;
   assign sts.wrap_more = loops_ff[cmd.voice] && (adv >= limit) && (wrapped >= limit);
   assign rsp_word      = rsp_ff;

   always_comb begin
      free_v     = '0;
      free_found = 1'b0;
      for (int v = VOICES - 1; v >= 0; v--) begin
         if (!active_ff[v]) begin
            free_v     = VOICE_BITS'(v);
            free_found = 1'b1;
         end
      end
   end

   assign ipos     = pos_ff[cmd.voice][31:16];
   assign last_idx = ({1'b0, ipos} + 17'd1) == length_ff[cmd.voice];
   assign rd_addr  = cmd.rd_right ? base_ff[cmd.voice] + ipos + 16'd1
                                  : base_ff[cmd.voice] + ipos;

   always_ff @(posedge clock) begin
      if (cmd.exec_simple && req_ff.op == OP_WRITE) begin
         mem[req_ff.address[SAMPLE_ADDR_BITS-1:0]] <= req_ff.sample_value;
      end
      rd_ff <= mem[rd_addr[SAMPLE_ADDR_BITS-1:0]];
   end

   assign right_val = last_idx ? left_ff : rd_ff;

   // left*(65536-f) + right*f == left*65536 + (right-left)*f
   assign prod_in = 34'(signed'({right_val[15], right_val} - {left_ff[15], left_ff}))
                    * 34'(signed'({1'b0, pos_ff[cmd.voice][15:0]}));
   always_comb begin
      interp_q = ({{2{left_ff[15]}}, left_ff, 16'd0} + prod_ff);
      // truncate toward zero
      if (interp_q < 0 && interp_q[15:0] != 16'd0) begin
         interp_q = interp_q + 34'sd65536;
      end
   end
   assign sum = 18'(mix_ff) + 18'(signed'(interp_q[33:16]));
   always_comb begin
      if (sum > 18'(SAT_MAX))      sat = SAT_MAX;
      else if (sum < 18'(SAT_MIN)) sat = SAT_MIN;
      else                         sat = sum[16:0];
   end

   assign adv      = {1'b0, pos_ff[cmd.voice]} + 33'(rate_ff[cmd.voice]);
   assign limit    = {length_ff[cmd.voice], 16'd0};
   assign wrapped  = adv - limit;
   assign wrap_amt = {8'd0, limit} << cmd.shift;

   always_comb begin
      active_in = active_ff;
      if (cmd.exec_simple) begin
         if (req_ff.op == OP_START && free_found) active_in[free_v] = 1'b1;
         if (req_ff.op == OP_STOP) begin
            for (int v = 0; v < VOICES; v++) begin
               if (id_ff[v] == req_ff.stop_handle) active_in[v] = 1'b0;
            end
         end
      end
      if (cmd.acc && adv >= limit && !loops_ff[cmd.voice]) active_in[cmd.voice] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         handle_ff <= 16'd1;
         loops_ff  <= '0;
         for (int v = 0; v < VOICES; v++) begin
            base_ff[v]   <= '0;
            length_ff[v] <= '0;
            pos_ff[v]    <= '0;
            rate_ff[v]   <= '0;
            id_ff[v]     <= '0;
         end
      end else begin
         active_ff <= active_in;
         if (cmd.exec_simple && req_ff.op == OP_START && free_found) begin
            base_ff[free_v]   <= req_ff.address;
            length_ff[free_v] <= (req_ff.sound_length == 17'd0) ? 17'd1 :
                                 (req_ff.sound_length > 17'h10000) ? 17'h10000 :
                                 req_ff.sound_length;
            pos_ff[free_v]    <= '0;
            rate_ff[free_v]   <= req_ff.step_rate;
            loops_ff[free_v]  <= req_ff.loop_flag;
            id_ff[free_v]     <= handle_ff;
            handle_ff         <= handle_ff + 16'd1;
         end
         if (cmd.acc) begin
            // subtract once; short sounds finish the wrap one shift per cycle
            if (adv < limit)                pos_ff[cmd.voice] <= adv[31:0];
            else if (loops_ff[cmd.voice])   pos_ff[cmd.voice] <= wrapped[31:0];
            else                            pos_ff[cmd.voice] <= '0;
         end
         if (cmd.wrap && {9'd0, pos_ff[cmd.voice]} >= wrap_amt) begin
            pos_ff[cmd.voice] <= pos_ff[cmd.voice] - wrap_amt[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_in;
         mix_ff <= 17'(req_in.sample_value);
      end
      if (cmd.rd_right) left_ff <= rd_ff;
      if (cmd.acc) begin
         mix_ff <= sat;
      end
      prod_ff <= prod_in;
      if (cmd.exec_simple) begin
         rsp_ff.mixed_sample <= (req_ff.op == OP_MIX) ? mix_ff[15:0] : 16'sd0;
         rsp_ff.voice_handle <= (req_ff.op == OP_START && free_found) ? handle_ff : 16'd0;
         rsp_ff.rejected     <= (req_ff.op == OP_START) && !free_found;
      end
   end

endmodule

### rtl/isvm_controller.sv
// Controller state machine: handshakes and per-voice sequencing for mix requests.
// Depends on isvm_pkg; commands isvm_datapath.
module isvm_controller
   import isvm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  op_type  req_op,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type             state_ff, state_in;
   logic [VOICE_BITS-1:0] voice_ff, voice_in;
   logic [2:0]            shift_ff, shift_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found;
   logic [VOICE_BITS-1:0] next_v;

   assign rsp_valid = rsp_valid_ff;

   // next active voice above the current one, or the lowest active voice when idle
   always_comb begin
      found  = 1'b0;
      next_v = '0;
      for (int v = VOICES - 1; v >= 0; v--) begin
         if (sts.active[v] && (state_ff == ST_IDLE || v > int'(voice_ff))) begin
            found  = 1'b1;
            next_v = VOICE_BITS'(v);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         voice_ff     <= '0;
         shift_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         voice_ff     <= voice_in;
         shift_ff     <= shift_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      voice_in     = voice_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.voice    = voice_ff;
      cmd.shift    = shift_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               voice_in = '0;
               state_in = ST_DONE;
               if (req_op == OP_MIX && sts.active != '0) begin
                  voice_in = next_v;
                  state_in = ST_RD_LEFT;
               end
            end
         end
         ST_RD_LEFT: begin
            cmd.rd_left = 1'b1;
            state_in    = ST_RD_RIGHT;
         end
         ST_RD_RIGHT: begin
            cmd.rd_right = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (sts.wrap_more) begin
               shift_in = WRAP_TOP;
               state_in = ST_WRAP;
            end else begin
               state_in = ST_DONE;
               if (found) begin
                  voice_in = next_v;
                  state_in = ST_RD_LEFT;
               end
            end
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
            shift_in = shift_ff - 3'd1;
            if (shift_ff == 3'd0) begin
               state_in = ST_DONE;
               if (found) begin
                  voice_in = next_v;
                  state_in = ST_RD_LEFT;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.exec_simple = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### rtl/interpolating_sample_voice_mixer_unit.sv
// Top level of the interpolating sample voice mixer.
// Write, start and stop go idle to done; mix reads, multiplies and adds per voice,
// plus wrap steps when a looping voice passes its end more than once in one step.
// One item at a time; the voice loop through the shared multiplier sets the rate.
// Synchronous active-high reset clears voices and sets the next handle to one;
// sample memory is undefined until written. No clearing pass.
module interpolating_sample_voice_mixer_unit
   import isvm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   cmd_type cmd;
   sts_type sts;

   isvm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_word.op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   isvm_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_in   (req_word),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp_word)
   );

endmodule
